### src/pmm_pkg.sv
// shared constants and types for the polynomial multiplier mod 2^64
`timescale 1ns / 1ps

package pmm_pkg;

    localparam int COEFF_W     = 64;
    localparam int HALF_W      = COEFF_W / 2;
    localparam int IDX_W       = 9;
    localparam int LEN_W       = 9;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int DEF_MAX_LEN = 256;

    localparam logic [CMD_W-1:0] CMD_WR_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RD   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEN_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_B = 1'b1;

    // control that travels alongside one multiply-add beat
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
        logic oor;
    } t_mac_ctl;

endpackage

### src/pmm_ram.sv
// generic single-write, single-read synchronous ram with registered read
`timescale 1ns / 1ps

module pmm_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/pmm_mac.sv
// split 64x64 multiply pipeline and wrapping accumulator
`timescale 1ns / 1ps

module pmm_mac
    import pmm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mac_ctl           i_ctl,
    input  logic [COEFF_W-1:0] i_a,
    input  logic [COEFF_W-1:0] i_b,
    output logic               o_done,
    output logic [COEFF_W-1:0] o_value,
    output logic               o_oor
);

    t_mac_ctl           r_ctl_d;
    t_mac_ctl           r_ctl_m;
    t_mac_ctl           r_ctl_s;
    logic [COEFF_W-1:0] r_p0;
    logic [HALF_W-1:0]  r_p1;
    logic [HALF_W-1:0]  r_p2;
    logic [COEFF_W-1:0] r_prod;
    logic [COEFF_W-1:0] r_acc;
    logic               r_oor;
    logic               r_done;
    logic [COEFF_W-1:0] n_acc;
    logic [HALF_W-1:0]  n_cross;
    logic [HALF_W-1:0]  n_p1;
    logic [HALF_W-1:0]  n_p2;

    // control valids, aligned with ram data, products, sum and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_d <= '0;
            r_ctl_m <= '0;
            r_ctl_s <= '0;
            r_done  <= 1'b0;
        end else begin
            r_ctl_d <= i_ctl;
            r_ctl_m <= r_ctl_d;
            r_ctl_s <= r_ctl_m;
            r_done  <= r_ctl_s.vld & r_ctl_s.last;
        end
    end

    // only the low 64 bits matter: lo*lo plus the low halves of the cross terms
    always_comb begin
        n_p1      = i_a[HALF_W-1:0] * i_b[COEFF_W-1:HALF_W];
        n_p2      = i_a[COEFF_W-1:HALF_W] * i_b[HALF_W-1:0];
        n_cross   = r_p1 + r_p2;
        if (r_ctl_s.oor) begin
            n_acc = '0;
        end else if (r_ctl_s.first) begin
            n_acc = r_prod;
        end else begin
            n_acc = r_acc + r_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ctl_d.vld) begin
            r_p0 <= {{HALF_W{1'b0}}, i_a[HALF_W-1:0]} * {{HALF_W{1'b0}}, i_b[HALF_W-1:0]};
            r_p1 <= n_p1;
            r_p2 <= n_p2;
        end
        if (r_ctl_m.vld) begin
            r_prod <= r_p0 + {n_cross, {HALF_W{1'b0}}};
        end
        if (r_ctl_s.vld) begin
            r_acc <= n_acc;
            r_oor <= r_ctl_s.oor;
        end
    end

    assign o_done  = r_done;
    assign o_value = r_acc;
    assign o_oor   = r_oor;

endmodule

### src/pmm_seq.sv
// command decode and term sequencer for product coefficient reads
`timescale 1ns / 1ps

module pmm_seq
    import pmm_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN,
    parameter int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [IDX_W-1:0]  i_idx,
    input  logic [LEN_W-1:0]  i_len_a,
    input  logic [LEN_W-1:0]  i_len_b,
    input  logic              i_done,
    output logic              o_busy,
    output logic              o_we_a,
    output logic              o_we_b,
    output logic [ADDR_W-1:0] o_waddr,
    output logic              o_re,
    output logic [ADDR_W-1:0] o_raddr_a,
    output logic [ADDR_W-1:0] o_raddr_b,
    output t_mac_ctl          o_ctl
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = ((LW > LEN_W) ? LW : LEN_W) + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    function automatic logic [CW-1:0] eff_len(input logic [LEN_W-1:0] v);
        logic [CW-1:0] x;
        x = CW'(v);
        if (x == '0) begin
            return CW'(1);
        end else if (x > CW'(MAX_LEN)) begin
            return CW'(MAX_LEN);
        end
        return x;
    endfunction

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_hi;
    logic          r_oor;
    logic          r_first;
    logic [CW-1:0] n_k;
    logic [CW-1:0] n_la;
    logic [CW-1:0] n_lb;
    logic [CW-1:0] n_lo;
    logic          n_accept;
    logic          n_last;

    always_comb begin
        n_k      = CW'(i_idx);
        n_la     = eff_len(i_len_a);
        n_lb     = eff_len(i_len_b);
        n_accept = i_start & (r_state == ST_IDLE);
        // first a index whose b partner still lies inside b
        n_lo     = (n_k >= n_lb) ? (n_k - n_lb + CW'(1)) : '0;
        n_last   = r_oor | (r_i == r_hi);
        n_state  = r_state;
        case (r_state)
            ST_IDLE: begin
                if (n_accept && i_cmd == CMD_RD) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (n_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (i_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_i     <= n_lo;
            r_j     <= n_k - n_lo;
            r_hi    <= (n_k < n_la) ? n_k : (n_la - CW'(1));
            r_oor   <= (n_k >= n_la + n_lb - CW'(1));
            r_first <= 1'b1;
        end else if (r_state == ST_ISSUE) begin
            r_i     <= r_i + CW'(1);
            r_j     <= r_j - CW'(1);
            r_first <= 1'b0;
        end
    end

    assign o_busy    = (r_state != ST_IDLE);
    assign o_we_a    = n_accept & (i_cmd == CMD_WR_A) & (n_k < n_la);
    assign o_we_b    = n_accept & (i_cmd == CMD_WR_B) & (n_k < n_lb);
    assign o_waddr   = n_k[ADDR_W-1:0];
    assign o_re      = (r_state == ST_ISSUE);
    assign o_raddr_a = r_i[ADDR_W-1:0];
    assign o_raddr_b = r_j[ADDR_W-1:0];

    always_comb begin
        o_ctl.vld   = (r_state == ST_ISSUE);
        o_ctl.first = r_first;
        o_ctl.last  = n_last;
        o_ctl.oor   = r_oor;
    end

endmodule

### src/poly_multiply_mod_2_64_top.sv
// top level: product coefficient of two polynomials with coefficients mod 2^64
// writes may follow back to back and busy stays low for them; a read of coefficient k
// with n terms (n = 1 when out of range) holds busy until its result shows on o_done,
// one multiply-add issued per term; the next start is taken in the cycle after o_done
// synchronous active-low reset clears control and sets both lengths to 1; stores are not cleared
`timescale 1ns / 1ps

module poly_multiply_mod_2_64_top
    import pmm_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic [CMD_W-1:0]          i_cmd,
    input  logic [IDX_W-1:0]          i_coeff_index,
    input  logic signed [COEFF_W-1:0] i_coeff_value,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [LEN_W-1:0]          i_cfg_data,
    output logic                      o_done,
    output logic signed [COEFF_W-1:0] o_product_value,
    output logic                      o_out_of_range
);

    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [LEN_W-1:0]   r_len_a;
    logic [LEN_W-1:0]   r_len_b;
    logic               we_a;
    logic               we_b;
    logic [ADDR_W-1:0]  waddr;
    logic               re;
    logic [ADDR_W-1:0]  raddr_a;
    logic [ADDR_W-1:0]  raddr_b;
    logic [COEFF_W-1:0] rdata_a;
    logic [COEFF_W-1:0] rdata_b;
    logic [COEFF_W-1:0] acc_value;
    t_mac_ctl           mac_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a <= LEN_W'(1);
            r_len_b <= LEN_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_LEN_A) begin
                r_len_a <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_LEN_B) begin
                r_len_b <= i_cfg_data;
            end
        end
    end

    pmm_seq #(
        .MAX_LEN (MAX_LEN),
        .ADDR_W  (ADDR_W)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_cmd     (i_cmd),
        .i_idx     (i_coeff_index),
        .i_len_a   (r_len_a),
        .i_len_b   (r_len_b),
        .i_done    (o_done),
        .o_busy    (o_busy),
        .o_we_a    (we_a),
        .o_we_b    (we_b),
        .o_waddr   (waddr),
        .o_re      (re),
        .o_raddr_a (raddr_a),
        .o_raddr_b (raddr_b),
        .o_ctl     (mac_ctl)
    );

    pmm_ram #(
        .WIDTH  (COEFF_W),
        .DEPTH  (MAX_LEN),
        .ADDR_W (ADDR_W)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata ($unsigned(i_coeff_value)),
        .i_re    (re),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    pmm_ram #(
        .WIDTH  (COEFF_W),
        .DEPTH  (MAX_LEN),
        .ADDR_W (ADDR_W)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata ($unsigned(i_coeff_value)),
        .i_re    (re),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    pmm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (rdata_a),
        .i_b     (rdata_b),
        .o_done  (o_done),
        .o_value (acc_value),
        .o_oor   (o_out_of_range)
    );

    assign o_product_value = $signed(acc_value);

    // a result beat only ever ends a read still in flight
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy)
        else $error("result beat while sequencer idle");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out_of_range) |-> (o_product_value == '0))
        else $error("out of range result is not zero");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd == CMD_RD) |=> o_busy)
        else $error("read accepted but sequencer not busy");

    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd != CMD_RD) |=> !o_busy)
        else $error("write or ignored command made block busy");

    a_issue_vs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_ctl.vld |-> !o_done)
        else $error("result beat while terms still being issued");

endmodule

### tb/tb_top.sv
// self-checking testbench for the mod 2^64 polynomial multiplier top level
`timescale 1ns / 1ps

module tb_top;
    import pmm_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RST_CYCLES    = 7;
    localparam int ITEM_GOAL     = 1700;
    localparam int QUIET_FROM    = 1450;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 300;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int MAX_REPORTS   = 10;

    localparam logic [CMD_W-1:0]   CMD_NONE = 2'd3;
    localparam logic [COEFF_W-1:0] V_MIN    = 64'h8000_0000_0000_0000;
    localparam logic [COEFF_W-1:0] V_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [COEFF_W-1:0] V_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
    // multiplicative inverse of 3 mod 2^64
    localparam logic [COEFF_W-1:0] V_INV3   = 64'hAAAA_AAAA_AAAA_AAAB;

    typedef enum logic {ROW_BEAT, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CMD_W-1:0]      cmd;
        logic [IDX_W-1:0]      idx;
        logic [COEFF_W-1:0]    val;      // length on config rows
        logic [CFG_IDX_W-1:0]  cfg_reg;
        logic                  typed;
        logic [COEFF_W-1:0]    want_val;
        logic                  want_oor;
    } t_step_row;

    typedef struct {
        logic [COEFF_W-1:0] val;
        logic               oor;
    } t_prod;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_start = 1'b0;
    logic                      o_busy;
    logic [CMD_W-1:0]          i_cmd = CMD_WR_A;
    logic [IDX_W-1:0]          i_coeff_index = '0;
    logic [COEFF_W-1:0]        i_coeff_value = '0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_idx = CFG_LEN_A;
    logic [LEN_W-1:0]          i_cfg_data = '0;
    logic                      o_done;
    logic [COEFF_W-1:0]        o_product_value;
    logic                      o_out_of_range;

    poly_multiply_mod_2_64_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_cmd           (i_cmd),
        .i_coeff_index   (i_coeff_index),
        .i_coeff_value   (i_coeff_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_product_value (o_product_value),
        .o_out_of_range  (o_out_of_range)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // shadow of the block: both coefficient stores and the two lengths
    logic [COEFF_W-1:0] coef_a [DEF_MAX_LEN];
    logic [COEFF_W-1:0] coef_b [DEF_MAX_LEN];
    logic [LEN_W-1:0]   len_a_q = 9'd1;
    logic [LEN_W-1:0]   len_b_q = 9'd1;

    t_prod     pending_prods [$];
    t_step_row dir_tab [24];

    int    fail_cnt = 0;
    int    n_wr_a = 0;
    int    n_wr_b = 0;
    int    n_rd = 0;
    int    n_oor = 0;
    int    n_skip = 0;
    int    n_phase = 0;
    longint cycle_cnt = 0;

    function automatic int eff_len(input logic [LEN_W-1:0] v);
        if (v == 0) return 1;
        if (int'(v) > DEF_MAX_LEN) return DEF_MAX_LEN;
        return int'(v);
    endfunction

    // applies one accepted beat to the shadow; returns 1 when a product comes out
    function automatic bit product_step(input logic [CMD_W-1:0] cmd,
                                        input logic [IDX_W-1:0] idx,
                                        input logic [COEFF_W-1:0] val,
                                        output t_prod res);
        int                 la;
        int                 lb;
        int                 k;
        logic [COEFF_W-1:0] acc;
        la = eff_len(len_a_q);
        lb = eff_len(len_b_q);
        k = int'(idx);
        acc = '0;
        res.val = '0;
        res.oor = 1'b0;
        case (cmd)
            CMD_WR_A: begin
                if (k < la) begin
                    coef_a[k] = val;
                    n_wr_a++;
                end else begin
                    n_skip++;
                end
                return 1'b0;
            end
            CMD_WR_B: begin
                if (k < lb) begin
                    coef_b[k] = val;
                    n_wr_b++;
                end else begin
                    n_skip++;
                end
                return 1'b0;
            end
            CMD_RD: begin
                n_rd++;
                if (k >= la + lb - 1) begin
                    res.oor = 1'b1;
                    n_oor++;
                    return 1'b1;
                end
                for (int i = 0; i < la && i <= k; i++) begin
                    if (k - i < lb) acc += coef_a[i] * coef_b[k - i];
                end
                res.val = acc;
                return 1'b1;
            end
            default: begin
                n_skip++;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void flag_fail(input string what);
        if (fail_cnt < MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, what);
        fail_cnt++;
    endfunction

    function automatic logic [COEFF_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return V_MIN;
            1: return V_MAX;
            2: return V_ONES;
            3: return '0;
            4: return 64'd1;
            5: return V_INV3;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // mostly short polynomials so reads stay cheap, now and then the extremes
    function automatic logic [LEN_W-1:0] pick_len();
        case ($urandom_range(0, 19))
            0: return 9'd0;
            1, 2: return 9'd1;
            3, 4: return 9'd256;
            5: return LEN_W'($urandom_range(257, 511));
            6, 7, 8: return LEN_W'($urandom_range(17, 255));
            default: return LEN_W'($urandom_range(2, 16));
        endcase
    endfunction

    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                             input logic [COEFF_W-1:0] val, input bit typed,
                             input t_prod want);
        t_prod res;
        bit    has;
        @(negedge i_clk);
        i_start       <= 1'b1;
        i_cmd         <= cmd;
        i_coeff_index <= idx;
        i_coeff_value <= val;
        do @(posedge i_clk); while (o_busy);
        has = product_step(cmd, idx, val, res);
        if (has) begin
            if (typed) pending_prods.push_back(want);
            else pending_prods.push_back(res);
        end
    endtask

    task automatic maybe_gap(input bit idle_on);
        int n;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 16);
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // sender holds off until every pending product is out and the block is quiet
    task automatic wait_idle();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_prods.size() != 0 || o_busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] r, input logic [LEN_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= r;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (r == CFG_LEN_A) len_a_q = d;
        else len_b_q = d;
    endtask

    task automatic random_beat(input bit idle_on);
        int                 r;
        int                 la;
        int                 lb;
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   idx;
        t_prod              none;
        none.val = '0;
        none.oor = 1'b0;
        la = eff_len(len_a_q);
        lb = eff_len(len_b_q);
        r = $urandom_range(0, 99);
        if (r < 5) cmd = CMD_NONE;
        else if (r < 35) cmd = CMD_WR_A;
        else if (r < 65) cmd = CMD_WR_B;
        else cmd = CMD_RD;
        if ($urandom_range(0, 99) < 15) idx = IDX_W'($urandom_range(0, 511));
        else if (cmd == CMD_RD) idx = IDX_W'($urandom_range(0, la + lb - 2));
        else if (cmd == CMD_WR_B) idx = IDX_W'($urandom_range(0, lb - 1));
        else idx = IDX_W'($urandom_range(0, la - 1));
        maybe_gap(idle_on);
        send_beat(cmd, idx, pick_value(), 1'b0, none);
    endtask

    // product checker: one beat per o_done, compared against the oldest pending product
    always @(posedge i_clk) begin
        t_prod want;
        if (i_rst_n && o_done) begin
            if (pending_prods.size() == 0) begin
                flag_fail($sformatf("unexpected product 0x%h oor %0b",
                                    o_product_value, o_out_of_range));
            end else begin
                want = pending_prods.pop_front();
                if (o_product_value !== want.val)
                    flag_fail($sformatf("product value: expected 0x%h, got 0x%h",
                                        want.val, o_product_value));
                if (o_out_of_range !== want.oor)
                    flag_fail($sformatf("out_of_range: expected %0b, got %0b",
                                        want.oor, o_out_of_range));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("ERROR: no progress within %0d cycles, %0d products pending",
                     CYCLE_LIMIT, pending_prods.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_prod want;
        bit    idle_on;
        int    n_beats;
        dir_tab = '{
            // after reset both lengths are 1, so anything past index 0 is out of range
            '{ROW_BEAT, CMD_RD,   9'd1,   64'd0,  CFG_LEN_A, 1'b1, 64'd0, 1'b1},
            '{ROW_BEAT, CMD_RD,   9'd510, 64'd0,  CFG_LEN_A, 1'b1, 64'd0, 1'b1},
            '{ROW_BEAT, CMD_WR_A, 9'd0,   V_MIN,  CFG_LEN_A, 1'b0, 64'd0, 1'b0},
            '{ROW_BEAT, CMD_WR_B, 9'd0,   V_ONES, CFG_LEN_A, 1'b0, 64'd0, 1'b0},
            '{ROW_BEAT, CMD_RD,   9'd0,   64'd0,  CFG_LEN_A, 1'b1, V_MIN, 1'b0},
            // writes past the length and the unused command must leave the stores alone
            '{ROW_BEAT, CMD_WR_A, 9'd1,   64'h0123_4567_89AB_CDEF,
              CFG_LEN_A, 1'b0, 64'd0, 1'b0},
            '{ROW_BEAT, CMD_WR_B, 9'd511, 64'h5555_5555_5555_5555,
              CFG_LEN_A, 1'b0, 64'd0, 1'b0},
            '{ROW_BEAT, CMD_NONE, 9'd0,   V_ONES, CFG_LEN_A, 1'b0, 64'd0, 1'b0},
            '{ROW_BEAT, CMD_RD,   9'd0,   64'd0,  CFG_LEN_A, 1'b1, V_MIN, 1'b0},
            // zero length acts as 1, oversize acts as 256
            '{ROW_CFG,  CMD_WR_A, 9'd0,   64'd0,   CFG_LEN_A, 1'b0, 64'd0, 1'b0},
            '{ROW_CFG,  CMD_WR_A, 9'd0,   64'd511, CFG_LEN_B, 1'b0, 64'd0, 1'b0},
            '{ROW_BEAT, CMD_RD,   9'd0,   64'd0,  CFG_LEN_A, 1'b1, V_MIN, 1'b0},
            '{ROW_BEAT, CMD_RD,   9'd256, 64'd0,  CFG_LEN_A, 1'b1, 64'd0, 1'b1},
            '{ROW_CFG,  CMD_WR_A, 9'd0,   64'd256, CFG_LEN_A, 1'b0, 64'd0, 1'b0},
            '{ROW_CFG,  CMD_WR_A, 9'd0,   64'd256, CFG_LEN_B, 1'b0, 64'd0, 1'b0},
            '{ROW_BEAT, CMD_WR_A, 9'd255, V_MAX,  CFG_LEN_A, 1'b0, 64'd0, 1'b0},
            '{ROW_BEAT, CMD_WR_B, 9'd255, V_MAX,  CFG_LEN_A, 1'b0, 64'd0, 1'b0},
            '{ROW_BEAT, CMD_WR_A, 9'd256, 64'hFEDC_BA98_7654_3210,
              CFG_LEN_A, 1'b0, 64'd0, 1'b0},
            // top coefficient: max * max wraps to 1
            '{ROW_BEAT, CMD_RD,   9'd510, 64'd0,  CFG_LEN_A, 1'b1, 64'd1, 1'b0},
            '{ROW_BEAT, CMD_RD,   9'd511, 64'd0,  CFG_LEN_A, 1'b1, 64'd0, 1'b1},
            '{ROW_BEAT, CMD_RD,   9'd0,   64'd0,  CFG_LEN_A, 1'b1, V_MIN, 1'b0},
            '{ROW_BEAT, CMD_WR_A, 9'd0,   V_INV3, CFG_LEN_A, 1'b0, 64'd0, 1'b0},
            '{ROW_BEAT, CMD_WR_B, 9'd0,   64'd3,  CFG_LEN_A, 1'b0, 64'd0, 1'b0},
            '{ROW_BEAT, CMD_RD,   9'd0,   64'd0,  CFG_LEN_A, 1'b1, 64'd1, 1'b0}
        };

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[r]) begin
            if (dir_tab[r].kind == ROW_CFG) begin
                wait_idle();
                cfg_write(dir_tab[r].cfg_reg, dir_tab[r].val[LEN_W-1:0]);
            end else begin
                want.val = dir_tab[r].want_val;
                want.oor = dir_tab[r].want_oor;
                send_beat(dir_tab[r].cmd, dir_tab[r].idx, dir_tab[r].val,
                          dir_tab[r].typed, want);
            end
        end

        // fill both stores completely; reads only reach indexes already filled
        want.val = '0;
        want.oor = 1'b0;
        wait_idle();
        cfg_write(CFG_LEN_A, 9'd300);
        cfg_write(CFG_LEN_B, 9'd256);
        n_phase = 1;
        for (int k = 0; k < DEF_MAX_LEN; k++) begin
            maybe_gap(1'b1);
            send_beat(CMD_WR_A, IDX_W'(k), pick_value(), 1'b0, want);
            maybe_gap(1'b1);
            send_beat(CMD_WR_B, IDX_W'(k), pick_value(), 1'b0, want);
            if ($urandom_range(0, 7) == 0)
                send_beat(CMD_RD, IDX_W'($urandom_range(0, k)), '0, 1'b0, want);
        end

        while (n_wr_a + n_wr_b + n_rd < ITEM_GOAL) begin
            wait_idle();
            if ($urandom_range(0, 1) == 0) begin
                cfg_write(CFG_LEN_A, pick_len());
                cfg_write(CFG_LEN_B, pick_len());
            end else begin
                cfg_write(CFG_LEN_B, pick_len());
                cfg_write(CFG_LEN_A, pick_len());
            end
            n_phase++;
            idle_on = (n_wr_a + n_wr_b + n_rd < QUIET_FROM) && ($urandom_range(0, 3) != 0);
            n_beats = $urandom_range(60, 160);
            repeat (n_beats) random_beat(idle_on);
        end

        @(negedge i_clk);
        i_start <= 1'b0;
        for (int w = 0; w < 4 * DRAIN_CYCLES && pending_prods.size() != 0; w++)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_prods.size() != 0)
            flag_fail($sformatf("%0d products never came out", pending_prods.size()));

        $display("coverage: %0d stores to a, %0d stores to b, %0d reads (%0d past the product)",
                 n_wr_a, n_wr_b, n_rd, n_oor);
        $display("coverage: %0d ignored beats, %0d length settings, %0d mismatches",
                 n_skip, n_phase + 2, fail_cnt);
        if (fail_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### files.f
src/pmm_pkg.sv
src/pmm_ram.sv
src/pmm_mac.sv
src/pmm_seq.sv
src/poly_multiply_mod_2_64_top.sv
tb/tb_top.sv
